>>> rtl/qcr_pkg.sv
`timescale 1ns / 1ps

package qcr_pkg;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_MS      = 2'd1;

    localparam logic [15:0] COUNTS_PER_REV_RST = 16'd1024;
    localparam logic [9:0]  UPDATE_MS_RST      = 10'd5;

    localparam int RPM_SCALE       = 60000;
    localparam int PROD_W          = 48;
    localparam int DVS_W           = 26;
    localparam int DIV_STEPS       = PROD_W;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        pin_a;
        logic        pin_b;
        logic [15:0] right_counter_raw;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] left_position;
        logic signed [15:0] right_position;
        logic signed [31:0] left_speed_rpm;
        logic signed [31:0] right_speed_rpm;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_TICK,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        pin_a;
        logic        pin_b;
        logic [15:0] raw;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_SAT,
        ST_EMIT
    } back_state_t;

endpackage

>>> rtl/qcr_front.sv
`timescale 1ns / 1ps

module qcr_front
    import qcr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output q_head_t  head,
    input  logic     pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               do_pop;
    q_entry_t           classified;

    // classify the incoming transaction
    always_comb
    begin
        classified.pin_a = in_data.pin_a;
        classified.pin_b = in_data.pin_b;
        classified.raw   = in_data.right_counter_raw;
        case (in_data.cmd)
            CMD_SAMPLE: classified.op = OP_SAMPLE;
            CMD_TICK:   classified.op = OP_TICK;
            CMD_CLEAR:  classified.op = OP_CLEAR;
            default:    classified.op = OP_NOP;
        endcase
    end

    assign in_stall    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push        = in_valid && !in_stall;
    assign do_pop      = pop && (count_reg != '0);
    assign head.valid  = (count_reg != '0);
    assign head.entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

>>> rtl/qcr_back.sv
`timescale 1ns / 1ps

module qcr_back
    import qcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] counts_per_rev,
    input  logic [9:0]  update_period_ms,
    input  q_head_t     head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    localparam logic signed [PROD_W-1:0] SCALE_S   = PROD_W'(RPM_SCALE);
    localparam logic [PROD_W-1:0]        POS_LIMIT = PROD_W'(32'h7FFF_FFFF);
    localparam logic [PROD_W-1:0]        NEG_LIMIT = PROD_W'(32'h8000_0000);
    localparam int                       CNT_W     = $clog2(DIV_STEPS);

    back_state_t               st_reg;
    back_state_t               st_next;

    logic [31:0]               edge_reg;
    logic [31:0]               edge_next;
    logic                      last_a_reg;
    logic                      last_a_next;
    logic                      a_known_reg;
    logic                      a_known_next;
    logic [31:0]               lprev_reg;
    logic [31:0]               lprev_next;
    logic signed [15:0]        rprev_reg;
    logic signed [15:0]        rprev_next;
    logic [31:0]               lspd_reg;
    logic [31:0]               lspd_next;
    logic [31:0]               rspd_reg;
    logic [31:0]               rspd_next;

    logic signed [31:0]        ldelta_reg;
    logic signed [31:0]        ldelta_next;
    logic signed [16:0]        rdelta_reg;
    logic signed [16:0]        rdelta_next;
    logic                      sel_reg;
    logic                      sel_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic [DVS_W-1:0]          dvs_reg;
    logic [DVS_W-1:0]          dvs_next;
    logic                      neg_reg;
    logic                      neg_next;
    logic [DVS_W-1:0]          rem_reg;
    logic [DVS_W-1:0]          rem_next;
    logic [PROD_W-1:0]         quo_reg;
    logic [PROD_W-1:0]         quo_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    out_item_t                 out_data_reg;
    out_item_t                 out_data_next;

    logic                      out_free;
    logic                      take;
    logic                      out_load;
    logic signed [31:0]        mul_op;
    logic [DVS_W:0]            trial;
    logic [31:0]               sat_val;
    logic [31:0]               lnow;
    logic signed [15:0]        rnow;

    assign out_free  = !out_valid_reg || !out_stall;
    assign take      = (st_reg == ST_IDLE) && head.valid && out_free;
    assign pop       = take;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign lnow   = 32'd0 - {edge_reg[30:0], 1'b0};
    assign rnow   = signed'(head.entry.raw);
    assign mul_op = sel_reg ? 32'(rdelta_reg) : ldelta_reg;
    assign trial  = {rem_reg, quo_reg[PROD_W-1]};

    always_comb
    begin
        if (dvs_reg == '0)
        begin
            sat_val = 32'd0;
        end
        else if (neg_reg)
        begin
            sat_val = (quo_reg > NEG_LIMIT) ? 32'h8000_0000 : 32'd0 - quo_reg[31:0];
        end
        else
        begin
            sat_val = (quo_reg > POS_LIMIT) ? 32'h7FFF_FFFF : quo_reg[31:0];
        end
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (take && (head.entry.op == OP_TICK))
                begin
                    st_next = ST_MUL;
                end
            end
            ST_MUL:  st_next = ST_PREP;
            ST_PREP: st_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    st_next = ST_SAT;
                end
            end
            ST_SAT:  st_next = sel_reg ? ST_EMIT : ST_MUL;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        edge_next      = edge_reg;
        last_a_next    = last_a_reg;
        a_known_next   = a_known_reg;
        lprev_next     = lprev_reg;
        rprev_next     = rprev_reg;
        lspd_next      = lspd_reg;
        rspd_next      = rspd_reg;
        ldelta_next    = ldelta_reg;
        rdelta_next    = rdelta_reg;
        sel_next       = sel_reg;
        prod_next      = prod_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_load       = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (head.entry.op)
                        OP_SAMPLE:
                        begin
                            out_load = 1'b1;
                            if (!a_known_reg)
                            begin
                                last_a_next  = head.entry.pin_a;
                                a_known_next = 1'b1;
                            end
                            else if (head.entry.pin_a != last_a_reg)
                            begin
                                last_a_next = head.entry.pin_a;
                                if (head.entry.pin_a != head.entry.pin_b)
                                begin
                                    edge_next = edge_reg + 32'd1;
                                end
                                else
                                begin
                                    edge_next = edge_reg - 32'd1;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            ldelta_next = signed'(lnow - lprev_reg);
                            rdelta_next = 17'(rnow) - 17'(rprev_reg);
                            lprev_next  = lnow;
                            rprev_next  = rnow;
                            sel_next    = 1'b0;
                        end
                        OP_CLEAR:
                        begin
                            out_load  = 1'b1;
                            edge_next = 32'd0;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_next = PROD_W'(mul_op) * SCALE_S;
                dvs_next  = DVS_W'(counts_per_rev) * DVS_W'(update_period_ms);
            end
            ST_PREP:
            begin
                neg_next = prod_reg[PROD_W-1];
                quo_next = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
                rem_next = '0;
                cnt_next = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                    quo_next = {quo_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DVS_W-1:0];
                    quo_next = {quo_reg[PROD_W-2:0], 1'b0};
                end
            end
            ST_SAT:
            begin
                if (sel_reg)
                begin
                    rspd_next = sat_val;
                end
                else
                begin
                    lspd_next = sat_val;
                    sel_next  = 1'b1;
                end
            end
            ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        out_data_next.left_position   = signed'(32'd0 - {edge_next[30:0], 1'b0});
        out_data_next.right_position  = rprev_next;
        out_data_next.left_speed_rpm  = signed'(lspd_next);
        out_data_next.right_speed_rpm = signed'(rspd_next);

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            edge_reg      <= '0;
            last_a_reg    <= 1'b0;
            a_known_reg   <= 1'b0;
            lprev_reg     <= '0;
            rprev_reg     <= '0;
            lspd_reg      <= '0;
            rspd_reg      <= '0;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            edge_reg      <= edge_next;
            last_a_reg    <= last_a_next;
            a_known_reg   <= a_known_next;
            lprev_reg     <= lprev_next;
            rprev_reg     <= rprev_next;
            lspd_reg      <= lspd_next;
            rspd_reg      <= rspd_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ldelta_reg <= ldelta_next;
        rdelta_reg <= rdelta_next;
        prod_reg   <= prod_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

>>> rtl/quadrature_count_and_rpm.sv
`timescale 1ns / 1ps

// channel  handshake          payload
// in       in_valid/in_stall  in_data    (in_item_t)
// out      out_valid/out_stall out_data  (out_item_t)
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// sample, clear and unused commands: one per cycle in back end while not stalled
// speed tick: runs through the shared one-bit-per-cycle restoring divider
//   (multiply, prepare, 48 divide steps, saturate; once per wheel)
// reset clears the decoder state, previous positions, speeds and the queue
// the input queue holds up to QUEUE_DEPTH transactions while the back end divides
//   or out_stall holds; in_stall is high while it is full

module quadrature_count_and_rpm
    import qcr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [15:0] cpr_reg;
    logic [9:0]  upd_reg;
    q_head_t     head;
    logic        pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg <= COUNTS_PER_REV_RST;
            upd_reg <= UPDATE_MS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COUNTS_PER_REV: cpr_reg <= cfg_data[15:0];
                CFG_UPDATE_MS:      upd_reg <= cfg_data[9:0];
                default:
                begin
                    cpr_reg <= cpr_reg;
                end
            endcase
        end
    end

    qcr_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .head     (head),
        .pop      (pop)
    );

    qcr_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .counts_per_rev   (cpr_reg),
        .update_period_ms (upd_reg),
        .head             (head),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_data         (out_data)
    );

endmodule
